[rtl/core/mi3_pkg.sv]
// shared constants and types for the 3x3 matrix inverse
// no dependencies
`default_nettype none
package mi3_pkg;

   localparam int unsigned MAT_DIM      = 3;
   localparam int unsigned MAT_ELEMS    = MAT_DIM * MAT_DIM;
   // products, cofactors, det partial products, signed terms, det sum
   localparam int unsigned FRONT_STAGES = 5;

   // cofactor k = a[i0]*a[i1] - a[i2]*a[i3]
   localparam int unsigned COF_IDX [MAT_ELEMS][4] = '{
      '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
      '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
      '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
   };

   typedef struct packed {
      logic neg;
      logic singular;
      logic pre_ovf;
   } mi3_flags_type;

endpackage
`default_nettype wire

[rtl/core/mi3_req_if.sv]
// request channel: one 3x3 matrix per transfer
// no dependencies
`default_nettype none
interface mi3_req_if #(parameter int unsigned ELEM_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [ELEM_WIDTH-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

   modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                   input ready);
   modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                   output ready);
endinterface
`default_nettype wire

[rtl/core/mi3_rsp_if.sv]
// response channel: inverse matrix and status flags per transfer
// no dependencies
`default_nettype none
interface mi3_rsp_if #(parameter int unsigned ELEM_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [ELEM_WIDTH-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
   logic                         singular;
   logic                         overflow;

   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   singular, overflow, input ready);
   modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   singular, overflow, output ready);
endinterface
`default_nettype wire

[rtl/core/mi3_front.sv]
// cofactors and determinant, five register stages
// depends on mi3_pkg
`default_nettype none
module mi3_front
   import mi3_pkg::*;
#(
   parameter int unsigned ELEM_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic [FRONT_STAGES-1:0]        en,
   input  wire logic signed [ELEM_WIDTH-1:0]   a_in   [MAT_ELEMS],
   output logic signed [3*ELEM_WIDTH:0]        det_out,
   output logic signed [2*ELEM_WIDTH:0]        cof_out [MAT_ELEMS]
);
   localparam int unsigned W = ELEM_WIDTH;

   logic signed [2*W-1:0] pa_ff   [MAT_ELEMS];
   logic signed [2*W-1:0] pb_ff   [MAT_ELEMS];
   logic signed [W-1:0]   row1_ff [MAT_DIM];
   logic signed [W-1:0]   row2_ff [MAT_DIM];
   logic signed [2*W:0]   cof2_ff [MAT_ELEMS];
   logic signed [2*W:0]   cof3_ff [MAT_ELEMS];
   logic signed [2*W:0]   cof4_ff [MAT_ELEMS];
   logic signed [2*W:0]   cof5_ff [MAT_ELEMS];
   logic [2*W-1:0]        mlo_ff  [MAT_DIM];
   logic [2*W-1:0]        mhi_ff  [MAT_DIM];
   logic [MAT_DIM-1:0]    sgn_ff;
   logic signed [3*W:0]   term_ff [MAT_DIM];
   logic signed [3*W:0]   det_ff;

   logic [W-1:0]          am_in   [MAT_DIM];
   logic [2*W-1:0]        cm_in   [MAT_DIM];
   logic [3*W-1:0]        mag_in  [MAT_DIM];

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAT_ELEMS; k++) begin
         if (en[0]) begin
            pa_ff[k] <= a_in[COF_IDX[k][0]] * a_in[COF_IDX[k][1]];
            pb_ff[k] <= a_in[COF_IDX[k][2]] * a_in[COF_IDX[k][3]];
         end
         if (en[1]) cof2_ff[k] <= {pa_ff[k][2*W-1], pa_ff[k]} - {pb_ff[k][2*W-1], pb_ff[k]};
         if (en[2]) cof3_ff[k] <= cof2_ff[k];
         if (en[3]) cof4_ff[k] <= cof3_ff[k];
         if (en[4]) cof5_ff[k] <= cof4_ff[k];
      end
      for (int k = 0; k < MAT_DIM; k++) begin
         if (en[0]) row1_ff[k] <= a_in[k];
         if (en[1]) row2_ff[k] <= row1_ff[k];
      end
   end

   always_comb begin
      for (int k = 0; k < MAT_DIM; k++) begin
         am_in[k]  = row2_ff[k][W-1] ? (~row2_ff[k] + 1'b1) : row2_ff[k];
         cm_in[k]  = cof2_ff[k][2*W] ? (~cof2_ff[k][2*W-1:0] + 1'b1)
                                     : cof2_ff[k][2*W-1:0];
         mag_in[k] = {mhi_ff[k], {W{1'b0}}} + {{W{1'b0}}, mlo_ff[k]};
      end
   end

   // |a| * |c| split into two W x W halves, recombined next stage
   always_ff @(posedge clock) begin
      for (int k = 0; k < MAT_DIM; k++) begin
         if (en[2]) begin
            mlo_ff[k] <= am_in[k] * cm_in[k][W-1:0];
            mhi_ff[k] <= am_in[k] * cm_in[k][2*W-1:W];
            sgn_ff[k] <= row2_ff[k][W-1] ^ cof2_ff[k][2*W];
         end
         if (en[3]) term_ff[k] <= sgn_ff[k] ? -$signed({1'b0, mag_in[k]})
                                            : $signed({1'b0, mag_in[k]});
      end
      if (en[4]) det_ff <= term_ff[0] + term_ff[1] + term_ff[2];
   end

   assign det_out = det_ff;
   assign cof_out = cof5_ff;

endmodule
`default_nettype wire

[rtl/core/mi3_lane.sv]
// one inverse element: rounding numerator, then a restoring divider
// with one quotient bit per stage; depends on mi3_pkg
`default_nettype none
module mi3_lane
   import mi3_pkg::*;
#(
   parameter int unsigned ELEM_WIDTH = 32,
   parameter int unsigned FRAC_BITS  = 16
) (
   input  wire logic                        clock,
   input  wire logic [ELEM_WIDTH+1:0]       en,
   input  wire logic signed [3*ELEM_WIDTH:0] det_in,
   input  wire logic signed [2*ELEM_WIDTH:0] cof_in,
   output logic [ELEM_WIDTH:0]              quo_out,
   output mi3_flags_type                    flags_out
);
   localparam int unsigned W  = ELEM_WIDTH;
   localparam int unsigned NW = 2 * W + 2 * FRAC_BITS + 2;
   localparam int unsigned XW = (NW > 4 * W + 3) ? NW : 4 * W + 3;
   localparam int unsigned NS = W + 2;

   logic [XW-1:0]    rem_ff   [NS];
   logic [3*W:0]     den_ff   [NS];
   logic [W:0]       quo_ff   [NS];
   mi3_flags_type    flags_ff [NS];

   logic [3*W-1:0]   dmag_in;
   logic [2*W-1:0]   cmag_in;
   logic [XW-1:0]    num_in;
   logic [3*W:0]     den2_in;

   always_comb begin
      dmag_in = det_in[3*W] ? (~det_in[3*W-1:0] + 1'b1) : det_in[3*W-1:0];
      cmag_in = cof_in[2*W] ? (~cof_in[2*W-1:0] + 1'b1) : cof_in[2*W-1:0];
      num_in  = (XW'(cmag_in) << (2 * FRAC_BITS + 1)) + XW'(dmag_in);
      den2_in = {dmag_in, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0]            <= num_in;
         den_ff[0]            <= den2_in;
         quo_ff[0]            <= '0;
         flags_ff[0].neg      <= cof_in[2*W] ^ det_in[3*W];
         flags_ff[0].singular <= (det_in == '0);
         // quotient would not fit in W+1 bits
         flags_ff[0].pre_ovf  <= (num_in >= (XW'(den2_in) << (W + 1)));
      end
   end

   for (genvar s = 1; s < NS; s++) begin : g_div
      localparam int unsigned BIT = NS - 1 - s;
      logic [XW-1:0] sh_in;
      logic          take_in;
      assign sh_in   = XW'(den_ff[s-1]) << BIT;
      assign take_in = (rem_ff[s-1] >= sh_in);
      always_ff @(posedge clock) begin
         if (en[s]) begin
            rem_ff[s]   <= take_in ? (rem_ff[s-1] - sh_in) : rem_ff[s-1];
            den_ff[s]   <= den_ff[s-1];
            quo_ff[s]   <= {quo_ff[s-1][W-1:0], take_in};
            flags_ff[s] <= flags_ff[s-1];
         end
      end
   end

   assign quo_out   = quo_ff[NS-1];
   assign flags_out = flags_ff[NS-1];

endmodule
`default_nettype wire

[rtl/core/mi3_merge.sv]
// saturation, sign and singular handling across the nine lanes;
// output register; depends on mi3_pkg
`default_nettype none
module mi3_merge
   import mi3_pkg::*;
#(
   parameter int unsigned ELEM_WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [ELEM_WIDTH:0]  quo_in   [MAT_ELEMS],
   input  wire mi3_flags_type        flags_in [MAT_ELEMS],
   output logic signed [ELEM_WIDTH-1:0] r_out [MAT_ELEMS],
   output logic                      singular_out,
   output logic                      overflow_out
);
   localparam int unsigned W = ELEM_WIDTH;
   localparam logic [W:0] LIM_POS = {2'b00, {(W-1){1'b1}}};
   localparam logic [W:0] LIM_NEG = {2'b01, {(W-1){1'b0}}};

   logic signed [W-1:0] r_ff [MAT_ELEMS];
   logic                singular_ff;
   logic                overflow_ff;

   logic [W:0]          lim_in [MAT_ELEMS];
   logic [W-1:0]        mag_in [MAT_ELEMS];
   logic [MAT_ELEMS-1:0] sat_in;

   always_comb begin
      for (int k = 0; k < MAT_ELEMS; k++) begin
         lim_in[k] = flags_in[k].neg ? LIM_NEG : LIM_POS;
         sat_in[k] = flags_in[k].pre_ovf || (quo_in[k] > lim_in[k]);
         mag_in[k] = sat_in[k] ? lim_in[k][W-1:0] : quo_in[k][W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < MAT_ELEMS; k++) begin
            if (flags_in[0].singular) r_ff[k] <= '0;
            else r_ff[k] <= flags_in[k].neg ? -$signed(mag_in[k]) : $signed(mag_in[k]);
         end
         singular_ff <= flags_in[0].singular;
         overflow_ff <= !flags_in[0].singular && (|sat_in);
      end
   end

   assign r_out        = r_ff;
   assign singular_out = singular_ff;
   assign overflow_out = overflow_ff;

endmodule
`default_nettype wire

[rtl/core/matrix_inverse_3x3.sv]
// top level of the 3x3 matrix inverse (adjugate over determinant)
// depends on mi3_pkg, mi3_req_if, mi3_rsp_if, mi3_front, mi3_lane, mi3_merge
//
//   channel    dir   payload
//   req_chan   in    a00..a22, signed Q(ELEM_WIDTH-FRAC_BITS).FRAC_BITS
//   rsp_chan   out   r00..r22, singular, overflow
//
// one matrix per cycle while rsp_chan is not stalled; stages in order: 5 front stages,
// numerator setup, ELEM_WIDTH+1 divider stages, output register
// the divider takes one quotient bit per stage in each of nine lanes
// each stage moves when empty or when the next one moves, so bubbles close up
// under a stalled rsp_chan; reset clears only the valid bits
`default_nettype none
module matrix_inverse_3x3
   import mi3_pkg::*;
#(
   parameter int unsigned ELEM_WIDTH = 32,
   parameter int unsigned FRAC_BITS  = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mi3_req_if.sink    req_chan,
   mi3_rsp_if.source  rsp_chan
);
   localparam int unsigned W     = ELEM_WIDTH;
   localparam int unsigned LANE0 = FRONT_STAGES;
   localparam int unsigned NST   = FRONT_STAGES + W + 3;

   logic [NST-1:0]        v_ff;
   logic [NST-1:0]        en;

   logic signed [W-1:0]   a_in    [MAT_ELEMS];
   logic signed [3*W:0]   det_w;
   logic signed [2*W:0]   cof_w   [MAT_ELEMS];
   logic [W:0]            quo_w   [MAT_ELEMS];
   mi3_flags_type         flags_w [MAT_ELEMS];
   logic signed [W-1:0]   r_w     [MAT_ELEMS];
   logic                  singular_w;
   logic                  overflow_w;

   assign en[NST-1] = !v_ff[NST-1] || rsp_chan.ready;
   for (genvar k = 0; k < NST - 1; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req_chan.valid;
         for (int k = 1; k < NST; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   assign req_chan.ready = en[0];

   assign a_in[0] = req_chan.a00;
   assign a_in[1] = req_chan.a01;
   assign a_in[2] = req_chan.a02;
   assign a_in[3] = req_chan.a10;
   assign a_in[4] = req_chan.a11;
   assign a_in[5] = req_chan.a12;
   assign a_in[6] = req_chan.a20;
   assign a_in[7] = req_chan.a21;
   assign a_in[8] = req_chan.a22;

   mi3_front #(.ELEM_WIDTH(W)) u_front (
      .clock   (clock),
      .en      (en[FRONT_STAGES-1:0]),
      .a_in    (a_in),
      .det_out (det_w),
      .cof_out (cof_w)
   );

   // lane for r(i,j) divides cofactor (j,i)
   for (genvar i = 0; i < MAT_DIM; i++) begin : g_row
      for (genvar j = 0; j < MAT_DIM; j++) begin : g_col
         mi3_lane #(.ELEM_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_lane (
            .clock     (clock),
            .en        (en[LANE0+W+1:LANE0]),
            .det_in    (det_w),
            .cof_in    (cof_w[j*MAT_DIM+i]),
            .quo_out   (quo_w[i*MAT_DIM+j]),
            .flags_out (flags_w[i*MAT_DIM+j])
         );
      end
   end

   mi3_merge #(.ELEM_WIDTH(W)) u_merge (
      .clock        (clock),
      .en           (en[NST-1]),
      .quo_in       (quo_w),
      .flags_in     (flags_w),
      .r_out        (r_w),
      .singular_out (singular_w),
      .overflow_out (overflow_w)
   );

   assign rsp_chan.valid    = v_ff[NST-1];
   assign rsp_chan.r00      = r_w[0];
   assign rsp_chan.r01      = r_w[1];
   assign rsp_chan.r02      = r_w[2];
   assign rsp_chan.r10      = r_w[3];
   assign rsp_chan.r11      = r_w[4];
   assign rsp_chan.r12      = r_w[5];
   assign rsp_chan.r20      = r_w[6];
   assign rsp_chan.r21      = r_w[7];
   assign rsp_chan.r22      = r_w[8];
   assign rsp_chan.singular = singular_w;
   assign rsp_chan.overflow = overflow_w;

   // input is refused only when every stage holds an item
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (&v_ff))
      else $error("input stalled with an empty stage");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.singular) |->
         (!rsp_chan.overflow && rsp_chan.r00 == '0 && rsp_chan.r11 == '0
          && rsp_chan.r22 == '0 && rsp_chan.r01 == '0 && rsp_chan.r10 == '0))
      else $error("singular result carries data or overflow");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=> (v_ff[NST-1] && $stable(rsp_chan.r00)))
      else $error("stalled result lost");

endmodule
`default_nettype wire
